@@ src/rgbncc_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbncc_pkg: shared types and constants of the RGB nearest color classifier
// Field widths, the reference color table and the sequencer state encoding.
// ----------------------------------------------------------------------------
package rgbncc_pkg;

    // Field widths
    localparam int RAW_W   = 10;
    localparam int NORM_W  = 17;
    localparam int CLASS_W = 4;
    localparam int REF_W   = 8;

    // Squared distance and its root; three 17-bit squares need 36 bits,
    // an even width for the two-bit root digits
    localparam int SUM_W   = 36;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int BEST_W  = 20;

    localparam logic [BEST_W-1:0] DIST_LIMIT = 20'd1000000;

    // Sequencer step counts
    localparam int DIV_STEPS  = NORM_W;
    localparam int SQ_STEPS   = 4;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int CNT_W      = 5;

    // Reference colors, {red, green, blue}
    localparam int TABLE_SIZE = 13;
    localparam logic [3*REF_W-1:0] REF_COLORS [TABLE_SIZE] = '{
        {8'd12,  8'd12,  8'd13},
        {8'd83,  8'd21,  8'd22},
        {8'd29,  8'd72,  8'd24},
        {8'd22,  8'd39,  8'd56},
        {8'd113, 8'd131, 8'd90},
        {8'd40,  8'd79,  8'd84},
        {8'd80,  8'd55,  8'd59},
        {8'd150, 8'd150, 8'd150},
        {8'd88,  8'd77,  8'd24},
        {8'd36,  8'd24,  8'd40},
        {8'd72,  8'd72,  8'd72},
        {8'd21,  8'd55,  8'd25},
        {8'd81,  8'd36,  8'd21}
    };

    // Configuration register indexes
    localparam logic [1:0] REG_WHITE_RED   = 2'd0;
    localparam logic [1:0] REG_WHITE_GREEN = 2'd1;
    localparam logic [1:0] REG_WHITE_BLUE  = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_SQRT,
        ST_CMP,
        ST_DONE
    } state_t;

endpackage

@@ src/rgb_nearest_color_classifier_top.sv @@
// ----------------------------------------------------------------------------
// rgb_nearest_color_classifier_top: nearest reference color of an RGB reading
// White-balances a raw reading and picks the closest of the reference colors.
// ----------------------------------------------------------------------------
// Usage
//   s_axis: one raw reading per request, tdata = {raw_blue, raw_green, raw_red}.
//   m_axis: one result per request, tdata = {norm_blue, norm_green, norm_red,
//           color_class}.
//   cfg:    write white_red (index 0), white_green (1), white_blue (2); always
//           ready, write only while no reading is in flight. Other indexes are
//           dropped.
// Sequence
//   One reading at a time. Three bit-serial restoring dividers run in parallel,
//   then each of the first min(NUM_COLORS, 13) reference colors takes squaring
//   (one 17x17 multiplier shared over the channels), a two-bit-per-cycle
//   square root and a compare. m_axis_tvalid rises after the last compare,
//   once the output register is free.
//   s_tready is high only while the sequencer is idle.
// Reset and stall
//   Reset returns the sequencer to idle, empties the output register and sets
//   the white references to 1023. A result waits in the output register while
//   m_tready is low and the next reading is already taken; a second finished
//   result holds in the sequencer until the register frees.
// ----------------------------------------------------------------------------
module rgb_nearest_color_classifier_top #(
    parameter int NUM_COLORS = 13
) (
    input  logic        clk,
    input  logic        rst_n,
    // raw_red [9:0], raw_green [19:10], raw_blue [29:20], zero [31:30]
    input  logic [31:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // color_class [3:0], norm_red [20:4], norm_green [37:21], norm_blue [54:38],
    // zero [55]
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);

    localparam int CLASS_W = rgbncc_pkg::CLASS_W;
    localparam int COLOR_COUNT = (NUM_COLORS < rgbncc_pkg::TABLE_SIZE) ?
                                 NUM_COLORS : rgbncc_pkg::TABLE_SIZE;
    localparam logic [CLASS_W-1:0] LAST_COLOR = CLASS_W'(COLOR_COUNT - 1);

    localparam int RAW_W  = rgbncc_pkg::RAW_W;
    localparam int NORM_W = rgbncc_pkg::NORM_W;
    localparam int SUM_W  = rgbncc_pkg::SUM_W;
    localparam int ROOT_W = rgbncc_pkg::ROOT_W;
    localparam int REM_W  = rgbncc_pkg::REM_W;
    localparam int BEST_W = rgbncc_pkg::BEST_W;
    localparam int CNT_W  = rgbncc_pkg::CNT_W;
    localparam int REF_W  = rgbncc_pkg::REF_W;

    // One restoring division step: shift in the next dividend bit, subtract
    // the divisor when it fits and shift the quotient bit into the dividend
    typedef struct packed {
        logic [RAW_W:0]    rem;
        logic [NORM_W-1:0] quo;
    } div_lane_t;

    function automatic div_lane_t div_step(input div_lane_t cur,
                                           input logic [RAW_W-1:0] divisor);
        logic [RAW_W:0] trial;
        logic           fits;
        div_lane_t      res;
        trial   = {cur.rem[RAW_W-1:0], cur.quo[NORM_W-1]};
        fits    = (trial >= {1'b0, divisor});
        res.rem = fits ? (trial - {1'b0, divisor}) : trial;
        res.quo = {cur.quo[NORM_W-2:0], fits};
        return res;
    endfunction

    // Scale a raw reading by 100 with shifts and adds
    function automatic logic [NORM_W-1:0] times_percent(input logic [RAW_W-1:0] raw);
        logic [NORM_W-1:0] r;
        r = NORM_W'(raw);
        return (r << 6) + (r << 5) + (r << 2);
    endfunction

    rgbncc_pkg::state_t state_reg, state_next;

    logic [RAW_W-1:0]  white_red_reg, white_green_reg, white_blue_reg;
    logic [RAW_W-1:0]  div_red, div_green, div_blue;
    div_lane_t         lane_red_reg, lane_green_reg, lane_blue_reg;
    div_lane_t         lane_red_next, lane_green_next, lane_blue_next;
    logic [CNT_W-1:0]  step_reg;
    logic [CLASS_W-1:0] color_reg, class_reg;
    logic [BEST_W-1:0] best_reg;

    logic [SUM_W-1:0]  acc_reg;
    logic [2*NORM_W-1:0] sq_reg;
    logic [SUM_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [55:0]       out_data_reg;
    logic              out_valid_reg;

    // Sequencer control outputs
    logic in_accept, div_last, sq_last, sqrt_last, color_last, out_load;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign out_load  = (state_reg == rgbncc_pkg::ST_DONE) &&
                       (!out_valid_reg || m_axis_tready);
    assign div_last  = (step_reg == CNT_W'(rgbncc_pkg::DIV_STEPS - 1));
    assign sq_last   = (step_reg == CNT_W'(rgbncc_pkg::SQ_STEPS - 1));
    assign sqrt_last = (step_reg == CNT_W'(rgbncc_pkg::SQRT_STEPS - 1));
    assign color_last = (color_reg == LAST_COLOR);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rgbncc_pkg::ST_IDLE: if (s_axis_tvalid) state_next = rgbncc_pkg::ST_DIV;
            rgbncc_pkg::ST_DIV:  if (div_last)      state_next = rgbncc_pkg::ST_SQ;
            rgbncc_pkg::ST_SQ:   if (sq_last)       state_next = rgbncc_pkg::ST_SQRT;
            rgbncc_pkg::ST_SQRT: if (sqrt_last)     state_next = rgbncc_pkg::ST_CMP;
            rgbncc_pkg::ST_CMP:
                state_next = color_last ? rgbncc_pkg::ST_DONE : rgbncc_pkg::ST_SQ;
            rgbncc_pkg::ST_DONE: if (out_load)      state_next = rgbncc_pkg::ST_IDLE;
            default:                                state_next = rgbncc_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_axis_tready = (state_reg == rgbncc_pkg::ST_IDLE);
        cfg_ready     = 1'b1;
        m_axis_tvalid = out_valid_reg;
        m_axis_tdata  = out_data_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rgbncc_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            white_red_reg   <= 10'd1023;
            white_green_reg <= 10'd1023;
            white_blue_reg  <= 10'd1023;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rgbncc_pkg::REG_WHITE_RED:   white_red_reg   <= cfg_data;
                rgbncc_pkg::REG_WHITE_GREEN: white_green_reg <= cfg_data;
                rgbncc_pkg::REG_WHITE_BLUE:  white_blue_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Treat a zero white reference as one
    assign div_red   = (white_red_reg   == '0) ? RAW_W'(1) : white_red_reg;
    assign div_green = (white_green_reg == '0) ? RAW_W'(1) : white_green_reg;
    assign div_blue  = (white_blue_reg  == '0) ? RAW_W'(1) : white_blue_reg;

    assign lane_red_next   = div_step(lane_red_reg,   div_red);
    assign lane_green_next = div_step(lane_green_reg, div_green);
    assign lane_blue_next  = div_step(lane_blue_reg,  div_blue);

    // Load the scaled reading, then divide one quotient bit a cycle
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            lane_red_reg.rem   <= '0;
            lane_green_reg.rem <= '0;
            lane_blue_reg.rem  <= '0;
            lane_red_reg.quo   <= times_percent(s_axis_tdata[RAW_W-1:0]);
            lane_green_reg.quo <= times_percent(s_axis_tdata[2*RAW_W-1:RAW_W]);
            lane_blue_reg.quo  <= times_percent(s_axis_tdata[3*RAW_W-1:2*RAW_W]);
        end
        else if (state_reg == rgbncc_pkg::ST_DIV)
        begin
            lane_red_reg   <= lane_red_next;
            lane_green_reg <= lane_green_next;
            lane_blue_reg  <= lane_blue_next;
        end
    end

    // Step counter, shared by the division, squaring and root phases
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            step_reg <= '0;
        else if (state_reg != state_next)
            step_reg <= '0;
        else
            step_reg <= step_reg + CNT_W'(1);
    end

    // Absolute channel difference against the current reference color, and its square
    logic [3*REF_W-1:0]  ref_color;
    logic [NORM_W-1:0]   chan_sig, chan_ref, chan_diff;
    logic [2*NORM_W-1:0] chan_sq;

    assign ref_color = rgbncc_pkg::REF_COLORS[color_reg];

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:
            begin
                chan_sig = lane_red_reg.quo;
                chan_ref = NORM_W'(ref_color[3*REF_W-1:2*REF_W]);
            end
            2'd1:
            begin
                chan_sig = lane_green_reg.quo;
                chan_ref = NORM_W'(ref_color[2*REF_W-1:REF_W]);
            end
            default:
            begin
                chan_sig = lane_blue_reg.quo;
                chan_ref = NORM_W'(ref_color[REF_W-1:0]);
            end
        endcase
        chan_diff = (chan_sig > chan_ref) ? (chan_sig - chan_ref) : (chan_ref - chan_sig);
        chan_sq   = chan_diff * chan_diff;
    end

    // Root step: bring down two radicand bits, subtract the trial when it fits
    logic [REM_W-1:0] rem_shift, rem_trial;
    logic             rem_fits;

    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[SUM_W-1:SUM_W-2]};
    assign rem_trial = {1'b0, root_reg, 2'b01};
    assign rem_fits  = (rem_shift >= rem_trial);

    // Square and accumulate, then take the root of the sum
    always_ff @(posedge clk)
    begin
        if (state_reg == rgbncc_pkg::ST_SQ)
        begin
            sq_reg <= chan_sq;
            if (step_reg == '0)
                acc_reg <= '0;
            else
                acc_reg <= acc_reg + SUM_W'(sq_reg);
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= acc_reg + SUM_W'(sq_reg);
        end
        else if (state_reg == rgbncc_pkg::ST_SQRT)
        begin
            rad_reg  <= {rad_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= rem_fits ? (rem_shift - rem_trial) : rem_shift;
            root_reg <= {root_reg[ROOT_W-2:0], rem_fits};
        end
    end

    // Keep the first smallest distance below the limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
            class_reg <= '0;
            best_reg  <= rgbncc_pkg::DIST_LIMIT;
        end
        else if (in_accept)
        begin
            color_reg <= '0;
            class_reg <= '0;
            best_reg  <= rgbncc_pkg::DIST_LIMIT;
        end
        else if (state_reg == rgbncc_pkg::ST_CMP)
        begin
            if (BEST_W'(root_reg) < best_reg)
            begin
                best_reg  <= BEST_W'(root_reg);
                class_reg <= color_reg;
            end
            if (!color_last)
                color_reg <= color_reg + CLASS_W'(1);
        end
    end

    // Output register: hold until the receiver takes the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= {1'b0, lane_blue_reg.quo, lane_green_reg.quo,
                             lane_red_reg.quo, class_reg};
    end

endmodule

@@ src/rgbncc_checker.sv @@
// ----------------------------------------------------------------------------
// rgbncc_checker: port-level checks of the RGB nearest color classifier
// Watches the stream ports and the result fields over time.
// ----------------------------------------------------------------------------
module rgbncc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or dropped");

    // Drop ready once a reading is taken
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second reading accepted while busy");

    // Keep the class within the table
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= 4'd12)
    else $error("class index out of range");

    // Keep the normalized red within its range
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:4] <= 17'd102300)
    else $error("normalized red out of range");

endmodule

bind rgb_nearest_color_classifier_top rgbncc_checker u_rgbncc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready)
);
